// ----- design/assert_macros.svh -----
// Assertion macros shared by the quaternion unit RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, ignored while reset is held.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also runs during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/qau_pkg.sv -----
// Package: payload types, operation and status codes for the quaternion unit.
package qau_pkg;

  localparam int CW  = 16;          // component width
  localparam int KW  = 3;           // operation code width
  localparam int STW = 2;           // status width
  localparam int SQW = 2 * CW + 1;  // sum of squares width
  localparam int RTW = CW + 1;      // square root width

  localparam logic [KW-1:0] KIND_MUL   = 3'd0;
  localparam logic [KW-1:0] KIND_ADD   = 3'd1;
  localparam logic [KW-1:0] KIND_SCALE = 3'd2;
  localparam logic [KW-1:0] KIND_CONJ  = 3'd3;
  localparam logic [KW-1:0] KIND_NORM  = 3'd4;
  localparam logic [KW-1:0] KIND_INV   = 3'd5;
  localparam logic [KW-1:0] KIND_UNIT  = 3'd6;

  localparam logic [STW-1:0] STAT_OK   = 2'd0;
  localparam logic [STW-1:0] STAT_SAT  = 2'd1;
  localparam logic [STW-1:0] STAT_ZERO = 2'd2;

  typedef logic signed [CW-1:0] comp_t;
  typedef logic [3:0][CW-1:0] quat_t;  // index 0 x, 1 y, 2 z, 3 w

  typedef struct packed {
    logic [KW-1:0] kind;
    comp_t         a_x;
    comp_t         a_y;
    comp_t         a_z;
    comp_t         a_w;
    comp_t         b_x;
    comp_t         b_y;
    comp_t         b_z;
    comp_t         b_w;
    comp_t         factor;
  } qau_in_t;

  typedef struct packed {
    comp_t          res_x;
    comp_t          res_y;
    comp_t          res_z;
    comp_t          res_w;
    logic [CW-1:0]  magnitude;
    logic [STW-1:0] status;
  } qau_out_t;

  // Front end result: direct ops finished, sum of squares ready
  typedef struct packed {
    logic [KW-1:0]  kind;
    quat_t          a;
    quat_t          rq;
    logic           sat;
    logic [SQW-1:0] ssq;
  } front_t;

  // Square root pipeline word
  typedef struct packed {
    front_t         fr;
    logic [SQW-1:0] rem;
    logic [RTW-1:0] root;
  } sqrt_t;

  // Divider pipeline word, four lanes
  typedef struct packed {
    logic [KW-1:0]        kind;
    quat_t                rq;
    logic                 sat;
    logic [RTW-1:0]       root;
    logic                 zero;
    logic [SQW-1:0]       den;
    logic [3:0][SQW-1:0]  rem;
    logic [3:0][CW-1:0]   nlo;
    logic [3:0][CW-1:0]   quo;
    logic [3:0]           ovf;
    logic [3:0]           neg;
  } div_t;

endpackage

// ----- design/qau_front.sv -----
// Front end: products, sums with rounding, clamping, and sum of squares.
`include "assert_macros.svh"

module qau_front
  import qau_pkg::*;
#(
  parameter int FRACTION_BITS = 12
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    adv,
  input  logic    in_valid,
  input  qau_in_t item,
  output logic    out_valid,
  output front_t  out
);

  localparam int PW = 2 * CW;
  localparam int MW = 2 * CW + 2;
  localparam logic signed [MW-1:0] HALF = MW'(1) <<< (FRACTION_BITS - 1);
  localparam logic signed [MW-1:0] SMAX = MW'((1 << (CW - 1)) - 1);
  localparam logic signed [MW-1:0] SMIN = -SMAX - MW'(1);

  typedef struct packed {
    logic [CW-1:0] val;
    logic          sat;
  } clamp_t;

  function automatic clamp_t clamp_comp(input logic signed [MW-1:0] v);
    clamp_t c;
    if (v > SMAX) begin
      c.val = SMAX[CW-1:0];
      c.sat = 1'b1;
    end else if (v < SMIN) begin
      c.val = SMIN[CW-1:0];
      c.sat = 1'b1;
    end else begin
      c.val = v[CW-1:0];
      c.sat = 1'b0;
    end
    return c;
  endfunction

  logic signed [CW-1:0] ain [4];
  logic signed [CW-1:0] bin [4];

  // stage 1 registers
  logic                 v1;
  logic [KW-1:0]        kind1;
  logic signed [CW-1:0] a1 [4];
  logic signed [CW-1:0] b1 [4];
  logic signed [PW-1:0] pab [4][4];
  logic signed [PW-1:0] pf [4];
  logic signed [PW-1:0] psq [4];

  // stage 2 logic and registers
  logic signed [MW-1:0] msum [4];
  logic signed [MW-1:0] rnd [4];
  logic signed [MW-1:0] scl [4];
  logic signed [MW-1:0] sel [4];
  logic [SQW-1:0]       ssq;
  logic                 v2;
  logic [KW-1:0]        kind2;
  quat_t                a2;
  logic signed [MW-1:0] sel2 [4];
  logic [SQW-1:0]       ssq2;

  // stage 3 logic
  clamp_t               cl [4];

  always_comb begin
    ain[0] = item.a_x;
    ain[1] = item.a_y;
    ain[2] = item.a_z;
    ain[3] = item.a_w;
    bin[0] = item.b_x;
    bin[1] = item.b_y;
    bin[2] = item.b_z;
    bin[3] = item.b_w;
  end

  // Stage 1: all products
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      kind1 <= item.kind;
      for (int i = 0; i < 4; i++) begin
        a1[i]  <= ain[i];
        b1[i]  <= bin[i];
        pf[i]  <= ain[i] * item.factor;
        psq[i] <= ain[i] * ain[i];
        for (int j = 0; j < 4; j++) begin
          pab[i][j] <= ain[i] * bin[j];
        end
      end
    end
  end

  // Stage 2: Hamilton sums, rounding, operation select
  always_comb begin
    msum[0] = MW'(pab[1][2]) - MW'(pab[2][1]) + MW'(pab[0][3]) + MW'(pab[3][0]);
    msum[1] = MW'(pab[2][0]) - MW'(pab[0][2]) + MW'(pab[1][3]) + MW'(pab[3][1]);
    msum[2] = MW'(pab[0][1]) - MW'(pab[1][0]) + MW'(pab[2][3]) + MW'(pab[3][2]);
    msum[3] = MW'(pab[3][3]) - MW'(pab[0][0]) - MW'(pab[1][1]) - MW'(pab[2][2]);
    ssq = '0;
    for (int i = 0; i < 4; i++) begin
      rnd[i] = (msum[i] + HALF) >>> FRACTION_BITS;
      scl[i] = (MW'(pf[i]) + HALF) >>> FRACTION_BITS;
      ssq = ssq + SQW'(unsigned'(psq[i]));
      unique case (kind1)
        KIND_MUL:   sel[i] = rnd[i];
        KIND_ADD:   sel[i] = MW'(a1[i]) + MW'(b1[i]);
        KIND_SCALE: sel[i] = scl[i];
        KIND_CONJ:  sel[i] = (i == 3) ? MW'(a1[i]) : -MW'(a1[i]);
        default:    sel[i] = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      kind2 <= kind1;
      ssq2  <= ssq;
      for (int i = 0; i < 4; i++) begin
        a2[i]   <= a1[i];
        sel2[i] <= sel[i];
      end
    end
  end

  // Stage 3: clamp to component range
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      cl[i] = clamp_comp(sel2[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out.kind <= kind2;
      out.a    <= a2;
      out.ssq  <= ssq2;
      out.sat  <= cl[0].sat | cl[1].sat | cl[2].sat | cl[3].sat;
      for (int i = 0; i < 4; i++) begin
        out.rq[i] <= cl[i].val;
      end
    end
  end

  `ASSERT_CLK(a_front_div_kinds_clear, out_valid && (out.kind == KIND_NORM || out.kind == KIND_INV || out.kind == KIND_UNIT) |-> out.rq == '0 && !out.sat, "front end produced a result for a norm-based kind")

endmodule

// ----- design/qau_sqrt_step.sv -----
// One digit of the pipelined integer square root.
module qau_sqrt_step
  import qau_pkg::*;
#(
  parameter int BIT = 0
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  adv,
  input  logic  in_valid,
  input  sqrt_t in_s,
  output logic  out_valid,
  output sqrt_t out_s
);

  localparam int TW = SQW + 1;

  logic [TW-1:0] trial;
  logic [TW-1:0] rem_ext;
  logic          take;
  sqrt_t         s_next;

  // Try this root bit against the remainder
  always_comb begin
    trial   = (TW'(in_s.root) << (BIT + 1)) | (TW'(1) << (2 * BIT));
    rem_ext = TW'(in_s.rem);
    take    = rem_ext >= trial;
    s_next  = in_s;
    if (take) begin
      s_next.rem  = SQW'(rem_ext - trial);
      s_next.root = in_s.root | (RTW'(1) << BIT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_s <= s_next;
    end
  end

endmodule

// ----- design/qau_div_step.sv -----
// One quotient bit of the four-lane pipelined restoring divider.
`include "assert_macros.svh"

module qau_div_step
  import qau_pkg::*;
#(
  parameter int BIT = 0
) (
  input  logic clk,
  input  logic rst,
  input  logic adv,
  input  logic in_valid,
  input  div_t in_d,
  output logic out_valid,
  output div_t out_d
);

  logic [SQW:0] r2 [4];
  logic [SQW:0] dext;
  div_t         d_next;

  // Shift in the next numerator bit, subtract when it fits
  always_comb begin
    d_next = in_d;
    dext   = {1'b0, in_d.den};
    for (int i = 0; i < 4; i++) begin
      r2[i] = {in_d.rem[i], in_d.nlo[i][BIT]};
      if (r2[i] >= dext) begin
        d_next.rem[i]      = SQW'(r2[i] - dext);
        d_next.quo[i][BIT] = 1'b1;
      end else begin
        d_next.rem[i] = SQW'(r2[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_d <= d_next;
    end
  end

  `ASSERT_CLK(a_div_rem_below_den, out_valid && !out_d.zero |-> (out_d.ovf[0] || out_d.rem[0] < out_d.den) && (out_d.ovf[1] || out_d.rem[1] < out_d.den) && (out_d.ovf[2] || out_d.rem[2] < out_d.den) && (out_d.ovf[3] || out_d.rem[3] < out_d.den), "divider remainder reached the divisor")

endmodule

// ----- design/quaternion_arithmetic_unit.sv -----
// Top level: quaternion ALU with a fully pipelined square root and divider.
//
// Input channel item_valid/item_ready/item carries one operation: kind, a, b
// and factor in signed Q4.12. Output channel result_valid/result_ready/result
// returns the four result components, the magnitude and a status for every
// item, in order.
// Every operation takes the same path: 3 front-end stages, 17 square root
// digit stages, 1 divider setup stage, 16 divider bit stages and the output
// register. One item is taken per cycle while the output register is
// empty or being taken; the square root and divider each have a stage per
// bit, so no unit is shared between items.
// The whole pipeline advances together whenever the output register is
// empty or being taken, so item_ready follows result_ready combinationally.
// While the receiver stalls with a full output register, every stage holds
// and no item is taken; nothing is dropped or repeated.
// Synchronous reset empties every stage; payload contents are not cleared.
`include "assert_macros.svh"

module quaternion_arithmetic_unit
  import qau_pkg::*;
#(
  parameter int FRACTION_BITS = 12
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     item_valid,
  output logic     item_ready,
  input  qau_in_t  item,
  output logic     result_valid,
  input  logic     result_ready,
  output qau_out_t result
);

  localparam int NW  = CW + 2 * FRACTION_BITS;
  localparam int CDW = (NW > SQW) ? NW : SQW;
  localparam logic [CW-1:0] CAP  = CW'(1) << (CW - 1);
  localparam logic [CW-1:0] SMXV = ~CAP;

  logic     adv;
  logic     fr_valid;
  front_t   fr_out;
  logic     sq_v [CW+2];
  sqrt_t    sq_s [CW+2];
  logic     pd_v;
  div_t     pd_s;
  div_t     pd_next;
  logic     dc_v [CW+1];
  div_t     dc_s [CW+1];

  front_t   pfr;
  logic     is_inv;
  logic [SQW-1:0] pden;
  logic [CW-1:0]  amag [4];
  logic [NW-1:0]  num [4];
  logic [NW-1:0]  nhi [4];

  div_t           fd;
  quat_t          rres;
  logic [CW-1:0]  qc [4];
  logic           fsat;
  qau_out_t       o_next;

  // Advance every stage when the output register can take a word
  assign adv        = !result_valid || result_ready;
  assign item_ready = adv;

  qau_front #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (item_valid),
    .item     (item),
    .out_valid(fr_valid),
    .out      (fr_out)
  );

  // Square root chain, one root bit per stage, most significant first
  assign sq_v[0]         = fr_valid;
  assign sq_s[0].fr      = fr_out;
  assign sq_s[0].rem     = fr_out.ssq;
  assign sq_s[0].root    = '0;

  for (genvar k = 0; k <= CW; k++) begin : g_sqrt
    qau_sqrt_step #(
      .BIT(CW - k)
    ) u_sqrt (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .in_valid (sq_v[k]),
      .in_s     (sq_s[k]),
      .out_valid(sq_v[k+1]),
      .out_s    (sq_s[k+1])
    );
  end

  // Divider setup: pick the divisor, scale the numerators, flag overflow
  always_comb begin
    pfr    = sq_s[CW+1].fr;
    is_inv = pfr.kind == KIND_INV;
    pden   = is_inv ? pfr.ssq : SQW'(sq_s[CW+1].root);
    pd_next      = '0;
    pd_next.kind = pfr.kind;
    pd_next.rq   = pfr.rq;
    pd_next.sat  = pfr.sat;
    pd_next.root = sq_s[CW+1].root;
    pd_next.den  = pden;
    pd_next.zero = pden == '0;
    for (int i = 0; i < 4; i++) begin
      amag[i] = pfr.a[i][CW-1] ? CW'(~pfr.a[i] + CW'(1)) : pfr.a[i];
      num[i]  = is_inv ? (NW'(amag[i]) << (2 * FRACTION_BITS))
                       : (NW'(amag[i]) << FRACTION_BITS);
      nhi[i]  = num[i] >> CW;
      pd_next.ovf[i] = CDW'(nhi[i]) >= CDW'(pden);
      pd_next.rem[i] = SQW'(nhi[i]);
      pd_next.nlo[i] = num[i][CW-1:0];
      pd_next.neg[i] = pfr.a[i][CW-1] ^ (is_inv && (i < 3));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pd_v <= 1'b0;
    end else if (adv) begin
      pd_v <= sq_v[CW+1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pd_s <= pd_next;
    end
  end

  // Divider chain, one quotient bit per stage, most significant first
  assign dc_v[0] = pd_v;
  assign dc_s[0] = pd_s;

  for (genvar k = 0; k < CW; k++) begin : g_div
    qau_div_step #(
      .BIT(CW - 1 - k)
    ) u_div (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .in_valid (dc_v[k]),
      .in_d     (dc_s[k]),
      .out_valid(dc_v[k+1]),
      .out_d    (dc_s[k+1])
    );
  end

  // Output stage: apply signs, clamp, build status
  always_comb begin
    fd     = dc_s[CW];
    rres   = '0;
    fsat   = 1'b0;
    o_next = '0;
    for (int i = 0; i < 4; i++) begin
      qc[i] = (fd.ovf[i] || fd.quo[i] > CAP) ? CAP : fd.quo[i];
    end
    unique case (fd.kind) inside
      KIND_MUL, KIND_ADD, KIND_SCALE, KIND_CONJ: begin
        rres = fd.rq;
        fsat = fd.sat;
      end
      KIND_NORM: begin
        if (fd.root[CW]) begin
          o_next.magnitude = '1;
          fsat = 1'b1;
        end else begin
          o_next.magnitude = fd.root[CW-1:0];
        end
      end
      KIND_INV, KIND_UNIT: begin
        if (!fd.zero) begin
          for (int i = 0; i < 4; i++) begin
            if (fd.neg[i]) begin
              rres[i] = CW'(~qc[i] + CW'(1));
            end else if (qc[i] == CAP) begin
              rres[i] = SMXV;
              fsat = 1'b1;
            end else begin
              rres[i] = qc[i];
            end
          end
        end
      end
      default: begin
        rres = '0;
      end
    endcase
    o_next.res_x = rres[0];
    o_next.res_y = rres[1];
    o_next.res_z = rres[2];
    o_next.res_w = rres[3];
    if ((fd.kind == KIND_INV || fd.kind == KIND_UNIT) && fd.zero) begin
      o_next.status = STAT_ZERO;
    end else if (fsat) begin
      o_next.status = STAT_SAT;
    end else begin
      o_next.status = STAT_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= dc_v[CW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result <= o_next;
    end
  end

  `ASSERT_CLK(a_zero_div_clears, result_valid && result.status == STAT_ZERO |-> result.res_x == '0 && result.res_y == '0 && result.res_z == '0 && result.res_w == '0 && result.magnitude == '0, "zero-norm division left a nonzero field")
  `ASSERT_CLK(a_magnitude_alone, result_valid && result.magnitude != '0 |-> result.res_x == '0 && result.res_y == '0 && result.res_z == '0 && result.res_w == '0 && result.status != STAT_ZERO, "norm result carried quaternion fields")
  `ASSERT_ALWAYS(a_reset_empties, $past(rst) |-> !result_valid && !pd_v, "pipeline not empty after reset")

endmodule
